// File: hw/rtl/assert_macros.svh
// assertion macros shared by the rtl of the newest-copy selector
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define LBCS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("lbcs assertion failed");
// condition must never be seen outside reset
`define LBCS_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("lbcs forbidden condition seen");
`else
`define LBCS_ASSERT(label, clk, rst_n, prop)
`define LBCS_NEVER(label, clk, rst_n, cond)
`endif
`endif

// File: hw/rtl/lbcs_pkg.sv
// shared types and constants of the newest-copy selector
package lbcs_pkg;

    // field widths
    localparam int VOL_W    = 7;
    localparam int LNUM_W   = 8;
    localparam int SEQ_W    = 64;
    localparam int LEN_W    = 25;
    localparam int OFS_W    = 32;
    localparam int CFG_IDX_W = 2;

    // default geometry of the sequence table
    localparam int LBCS_VOLUMES           = 128;
    localparam int LBCS_BLOCKS_PER_VOLUME = 256;

    // queue between front and back
    localparam int LBCS_QUEUE_DEPTH = 2;
    localparam int QPTR_W           = $clog2(LBCS_QUEUE_DEPTH);
    localparam int QCNT_W           = $clog2(LBCS_QUEUE_DEPTH + 1);

    // configuration register indexes
    typedef logic [CFG_IDX_W-1:0] t_cfg_index;
    localparam t_cfg_index REG_BLOCK_SIZE    = 2'd0;
    localparam t_cfg_index REG_PAYLOAD_START = 2'd1;

    // configuration reset values
    localparam logic [LEN_W-1:0] BLOCK_SIZE_RST    = 25'd131072;
    localparam logic [LEN_W-1:0] PAYLOAD_START_RST = 25'd4096;

    // classified item handed from front to back
    typedef struct packed {
        logic              drop;
        logic              internal_volume;
        logic [VOL_W-1:0]  volume_number;
        logic [LNUM_W-1:0] logical_block;
        logic [SEQ_W-1:0]  sequence_req;
        logic [LEN_W-1:0]  copy_length;
        logic              length_error;
    } t_item;

    // back end sequencer states
    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_LOOKUP
    } t_back_state;

endpackage

// File: hw/rtl/lbcs_queue.sv
// short fifo of classified items between front and back
module lbcs_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  lbcs_pkg::t_item i_item,
    input  logic          i_pop,
    output lbcs_pkg::t_item o_head,
    output logic          o_empty,
    output logic          o_full
);
    import lbcs_pkg::*;

    t_item             r_slot [LBCS_QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;
    logic              w_push, w_pop;

    // qualified push and pop
    assign w_push = i_push && !o_full;
    assign w_pop  = i_pop && !o_empty;

    // pointer and count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(LBCS_QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(LBCS_QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // item storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

    assign o_head  = r_slot[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == QCNT_W'(LBCS_QUEUE_DEPTH));

endmodule

// File: hw/rtl/lbcs_front.sv
// front end: configuration registers, item acceptance and classification
module lbcs_front #(
    parameter int VOLUMES           = lbcs_pkg::LBCS_VOLUMES,
    parameter int BLOCKS_PER_VOLUME = lbcs_pkg::LBCS_BLOCKS_PER_VOLUME
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [lbcs_pkg::VOL_W-1:0]   i_volume_number,
    input  logic [lbcs_pkg::LNUM_W-1:0]  i_logical_block,
    input  logic [lbcs_pkg::SEQ_W-1:0]   i_sequence_req,
    input  logic [lbcs_pkg::LEN_W-1:0]   i_pad_bytes,
    input  logic                         i_internal_volume,
    input  logic                         i_cfg_valid,
    input  lbcs_pkg::t_cfg_index         i_cfg_index,
    input  logic [lbcs_pkg::LEN_W-1:0]   i_cfg_data,
    input  logic                         i_queue_full,
    input  logic                         i_clearing,
    output logic                         o_busy,
    output logic                         o_push,
    output lbcs_pkg::t_item              o_item
);
    import lbcs_pkg::*;

    logic [LEN_W-1:0] r_block_size;
    logic [LEN_W-1:0] r_payload_start;
    logic [LEN_W:0]   w_used;
    logic             w_overrun;
    logic             w_out_of_range;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_size    <= BLOCK_SIZE_RST;
            r_payload_start <= PAYLOAD_START_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_BLOCK_SIZE:    r_block_size    <= i_cfg_data;
                REG_PAYLOAD_START: r_payload_start <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // payload length with saturation at zero
    assign w_used    = {1'b0, r_payload_start} + {1'b0, i_pad_bytes};
    assign w_overrun = (w_used > {1'b0, r_block_size});

    // table index outside the configured geometry
    assign w_out_of_range = (32'(i_volume_number) >= 32'(VOLUMES)) ||
                            (32'(i_logical_block) >= 32'(BLOCKS_PER_VOLUME));

    // accept and classify
    assign o_busy = i_queue_full || i_clearing;
    assign o_push = i_start && !o_busy;

    always_comb begin
        o_item.drop            = i_internal_volume || w_out_of_range;
        o_item.internal_volume = i_internal_volume;
        o_item.volume_number   = i_volume_number;
        o_item.logical_block   = i_logical_block;
        o_item.sequence_req    = i_sequence_req;
        o_item.copy_length     = w_overrun ? '0 : (r_block_size - w_used[LEN_W-1:0]);
        o_item.length_error    = w_overrun;
    end

endmodule

// File: hw/rtl/lbcs_back.sv
// back end: sequence table clear pass, read-modify-write and result register
`include "assert_macros.svh"
module lbcs_back #(
    parameter int VOLUMES           = lbcs_pkg::LBCS_VOLUMES,
    parameter int BLOCKS_PER_VOLUME = lbcs_pkg::LBCS_BLOCKS_PER_VOLUME
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lbcs_pkg::t_item             i_head,
    input  logic                        i_empty,
    output logic                        o_pop,
    output logic                        o_clearing,
    output logic                        o_result_valid,
    output logic                        o_copy_block,
    output logic                        o_internal_seen,
    output logic [lbcs_pkg::OFS_W-1:0]  o_out_offset,
    output logic [lbcs_pkg::LEN_W-1:0]  o_copy_length,
    output logic                        o_length_error
);
    import lbcs_pkg::*;

    localparam int DEPTH  = VOLUMES * BLOCKS_PER_VOLUME;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // newest sequence number per slot, zero means unseen
    logic [SEQ_W-1:0]  r_table [DEPTH];
    logic [SEQ_W-1:0]  r_rd_data;

    t_back_state       r_state, n_state;
    logic [ADDR_W-1:0] r_clr_addr;
    t_item             r_item;
    logic [ADDR_W-1:0] r_slot;
    logic [ADDR_W-1:0] w_head_slot;
    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    logic [SEQ_W-1:0]  w_wdata;
    logic              w_accept;
    logic [LEN_W+LNUM_W-1:0] w_product;

    logic              r_res_valid;
    logic              r_copy_block;
    logic              r_internal_seen;
    logic [OFS_W-1:0]  r_out_offset;
    logic [LEN_W-1:0]  r_copy_length;
    logic              r_length_error;

    // slot of the item at the queue head
    assign w_head_slot = ADDR_W'(32'(i_head.volume_number) * 32'(BLOCKS_PER_VOLUME)
                                + 32'(i_head.logical_block));

    // newer copy or first sighting wins
    assign w_accept = !r_item.drop &&
                      ((r_rd_data == '0) || (r_item.sequence_req > r_rd_data));

    assign w_product = r_item.copy_length * r_item.logical_block;

    // state register and clear counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= BK_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == BK_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    // next state, pop and table write port
    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        w_we    = 1'b0;
        w_waddr = r_slot;
        w_wdata = r_item.sequence_req;
        case (r_state)
            BK_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr_addr;
                w_wdata = '0;
                if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                    n_state = BK_IDLE;
                end
            end
            BK_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_state = BK_LOOKUP;
                end
            end
            BK_LOOKUP: begin
                w_we    = w_accept;
                n_state = BK_IDLE;
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // table memory with registered read
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_table[w_waddr] <= w_wdata;
        end
        r_rd_data <= r_table[w_head_slot];
    end

    // item held for the lookup cycle
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_head;
            r_slot <= w_head_slot;
        end
    end

    // result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= (r_state == BK_LOOKUP);
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (r_state == BK_LOOKUP) begin
            r_copy_block    <= w_accept;
            r_internal_seen <= r_item.internal_volume;
            r_out_offset    <= w_accept ? w_product[OFS_W-1:0] : '0;
            r_copy_length   <= w_accept ? r_item.copy_length : '0;
            r_length_error  <= w_accept && r_item.length_error;
        end
    end

    assign o_clearing      = (r_state == BK_CLEAR);
    assign o_result_valid  = r_res_valid;
    assign o_copy_block    = r_copy_block;
    assign o_internal_seen = r_internal_seen;
    assign o_out_offset    = r_out_offset;
    assign o_copy_length   = r_copy_length;
    assign o_length_error  = r_length_error;

    // checks
    `LBCS_ASSERT(a_result_after_lookup, i_clk, i_rst_n, r_res_valid |-> $past(r_state == BK_LOOKUP))
    `LBCS_NEVER(a_no_pop_while_clearing, i_clk, i_rst_n, o_pop && (r_state == BK_CLEAR))
    `LBCS_NEVER(a_copy_of_internal, i_clk, i_rst_n, r_res_valid && r_copy_block && r_internal_seen)
    `LBCS_NEVER(a_error_with_length, i_clk, i_rst_n, r_res_valid && r_length_error && (r_copy_length != '0))

endmodule

// File: hw/rtl/latest_block_copy_selector_top.sv
// top level of the newest-copy selector for flash erase blocks
//
// After reset the block clears its sequence table, one entry per cycle, for
// VOLUMES * BLOCKS_PER_VOLUME entries (32768 at the defaults); o_busy stays high
// meanwhile and configuration writes are still taken. An item is taken when
// i_start is high and o_busy is low; its result shows on the result ports for
// exactly one cycle with o_result_valid high, after the queue, the held item
// register and the result register when the back end is free and later while
// earlier items still wait in the queue, always one result per item and in
// order. The receiver cannot stall, so results must be taken as they come.
// Items are taken while a short queue has room; the back end ends one item's
// sequence table read-modify-write (registered read, then write) before the next.
module latest_block_copy_selector_top #(
    parameter int VOLUMES           = lbcs_pkg::LBCS_VOLUMES,
    parameter int BLOCKS_PER_VOLUME = lbcs_pkg::LBCS_BLOCKS_PER_VOLUME
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    output logic                        o_busy,
    input  logic [lbcs_pkg::VOL_W-1:0]  i_volume_number,
    input  logic [lbcs_pkg::LNUM_W-1:0] i_logical_block,
    input  logic [lbcs_pkg::SEQ_W-1:0]  i_sequence_req,
    input  logic [lbcs_pkg::LEN_W-1:0]  i_pad_bytes,
    input  logic                        i_internal_volume,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  lbcs_pkg::t_cfg_index        i_cfg_index,
    input  logic [lbcs_pkg::LEN_W-1:0]  i_cfg_data,
    output logic                        o_result_valid,
    output logic                        o_copy_block,
    output logic                        o_internal_seen,
    output logic [lbcs_pkg::OFS_W-1:0]  o_out_offset,
    output logic [lbcs_pkg::LEN_W-1:0]  o_copy_length,
    output logic                        o_length_error
);
    import lbcs_pkg::*;

    logic  w_push, w_pop, w_empty, w_full, w_clearing;
    t_item w_item, w_head;

    // configuration writes never wait
    assign o_cfg_ready = 1'b1;

    // accept and classify
    lbcs_front #(
        .VOLUMES           (VOLUMES),
        .BLOCKS_PER_VOLUME (BLOCKS_PER_VOLUME)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (i_start),
        .i_volume_number   (i_volume_number),
        .i_logical_block   (i_logical_block),
        .i_sequence_req    (i_sequence_req),
        .i_pad_bytes       (i_pad_bytes),
        .i_internal_volume (i_internal_volume),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_queue_full      (w_full),
        .i_clearing        (w_clearing),
        .o_busy            (o_busy),
        .o_push            (w_push),
        .o_item            (w_item)
    );

    // decoupling queue
    lbcs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_item),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    // table update and result
    lbcs_back #(
        .VOLUMES           (VOLUMES),
        .BLOCKS_PER_VOLUME (BLOCKS_PER_VOLUME)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (w_head),
        .i_empty         (w_empty),
        .o_pop           (w_pop),
        .o_clearing      (w_clearing),
        .o_result_valid  (o_result_valid),
        .o_copy_block    (o_copy_block),
        .o_internal_seen (o_internal_seen),
        .o_out_offset    (o_out_offset),
        .o_copy_length   (o_copy_length),
        .o_length_error  (o_length_error)
    );

endmodule
